// ----- rtl/fsd_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the shape drawer.
`timescale 1ns / 1ps
package fsd_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DIM_W      = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

  // Field widths
  localparam int PIX_W  = 32;
  localparam int POS_W  = 12;
  localparam int DIV_W  = 8;
  localparam int CFG_W  = 8;
  localparam int CRD_W  = 14;   // signed working coordinate
  localparam int ROOT_W = 11;   // radius and square root
  localparam int SQ_W   = 2 * ROOT_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [3:0] {
    OP_CLEAR      = 4'd0,
    OP_HSPAN      = 4'd1,
    OP_VSPAN      = 4'd2,
    OP_FILLRECT   = 4'd3,
    OP_RECT       = 4'd4,
    OP_GRID       = 4'd5,
    OP_CIRCLE     = 4'd6,
    OP_FILLCIRCLE = 4'd7,
    OP_READ       = 4'd8
  } opcode_t;

  // Span being drawn
  typedef enum logic [3:0] {
    SEG_CLR, SEG_HS, SEG_VS, SEG_FRECT, SEG_TOP, SEG_BOT, SEG_LEFT, SEG_RIGHT,
    SEG_GV, SEG_GH, SEG_CLO, SEG_CHI, SEG_FCIR
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_DIV, ST_SQ_MUL, ST_SQ_SUB, ST_SQRT, ST_SET, ST_ADDR,
    ST_RUN, ST_NEXT, ST_RD_ADDR, ST_RD_DATA, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    seg_t seg;
    logic span_set;
    logic span_addr;
    logic span_step;
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic sq_mul;
    logic sq_start;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       more;
    logic       last;
    logic       div_busy;
    logic       sqrt_busy;
    logic       rows_zero;
    logic       r_zero;
    logic       div_zero;
    logic       out_busy;
  } dp_sts_t;

endpackage

// ----- rtl/framebuffer_shape_drawer.sv -----
// Shape drawer top level: sequencer, datapath and frame store.
// Usage:
//   One command word enters on in_* (valid/ready) and returns exactly one
//   result word on out_* (valid/ready): pixel_value for a read, status for
//   a grid. frame_width/frame_height are to be written on cfg_* only while
//   idle; the block itself does not enforce it. It takes one command at a time.
//   Drawing speed follows from the single frame store write port, one pixel
//   per cycle while a span runs. Each command consists of:
//     span              one clipped span
//     clear             one full-width span per frame row
//     fillrect / rect   one span per row / four outline spans
//     grid              outline, then divider, then one span per line
//     circle            per column: square root, then its spans
//     read              one frame store read
//   The next command is accepted in the cycle that out_valid rises, at the
//   earliest, even while that word is still stalled in its output register.
//   A command that finishes while the previous result is unread holds
//   until out_ready frees the register.
//   Reset: both frame registers read 128, the frame store is not cleared
//   (write it, e.g. with clear, before reading).
`timescale 1ns / 1ps
module framebuffer_shape_drawer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    in_opcode,
  input  logic [fsd_pkg::POS_W-1:0]     in_pos_x,
  input  logic [fsd_pkg::POS_W-1:0]     in_pos_y,
  input  logic [fsd_pkg::POS_W-1:0]     in_end_x,
  input  logic [fsd_pkg::POS_W-1:0]     in_end_y,
  input  logic [fsd_pkg::POS_W-1:0]     in_size_w,
  input  logic [fsd_pkg::POS_W-1:0]     in_size_h,
  input  logic [fsd_pkg::DIV_W-1:0]     in_div_x,
  input  logic [fsd_pkg::DIV_W-1:0]     in_div_y,
  input  logic [fsd_pkg::POS_W-1:0]     in_diameter,
  input  logic [fsd_pkg::PIX_W-1:0]     in_paint,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fsd_pkg::PIX_W-1:0]     out_pixel_value,
  output logic                          out_status,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fsd_pkg::CFG_W-1:0]     cfg_data
);

  fsd_pkg::dp_cmd_t             cmd;
  fsd_pkg::dp_sts_t             sts;
  logic                         ram_we, ram_re;
  logic [fsd_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [fsd_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;

  // Sequencer
  fsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  fsd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_size_w       (in_size_w),
    .in_size_h       (in_size_h),
    .in_div_x        (in_div_x),
    .in_div_y        (in_div_y),
    .in_diameter     (in_diameter),
    .in_paint        (in_paint),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  // Frame store
  fsd_ram #(
    .WIDTH (fsd_pkg::PIX_W),
    .DEPTH (fsd_pkg::DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // No pixel is painted while the block waits for a command
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !in_ready)
    else $error("frame write while idle");

  // An accepted command keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted but block idle");

  // A result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result overwrote a pending word");

  // Reads and writes never share a cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame read and write together");
`endif

endmodule

// ----- rtl/fsd_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module fsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fsd_ctrl.sv -----
// Command sequencer: walks each command through its spans, divisions and roots.
`timescale 1ns / 1ps
module fsd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fsd_pkg::dp_sts_t sts,
  output fsd_pkg::dp_cmd_t cmd
);

  fsd_pkg::state_t state_r, state_nxt;
  fsd_pkg::seg_t   seg_r, seg_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsd_pkg::ST_IDLE;
      seg_r   <= fsd_pkg::SEG_CLR;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    case (state_r)
      fsd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = fsd_pkg::ST_DISPATCH;
      end
      fsd_pkg::ST_DISPATCH: begin
        state_nxt = fsd_pkg::ST_SET;
        case (sts.op)
          fsd_pkg::OP_CLEAR: seg_nxt = fsd_pkg::SEG_CLR;
          fsd_pkg::OP_HSPAN: seg_nxt = fsd_pkg::SEG_HS;
          fsd_pkg::OP_VSPAN: seg_nxt = fsd_pkg::SEG_VS;
          fsd_pkg::OP_FILLRECT: begin
            seg_nxt = fsd_pkg::SEG_FRECT;
            if (sts.rows_zero) state_nxt = fsd_pkg::ST_DONE;
          end
          fsd_pkg::OP_RECT, fsd_pkg::OP_GRID: seg_nxt = fsd_pkg::SEG_TOP;
          fsd_pkg::OP_CIRCLE: begin
            seg_nxt   = fsd_pkg::SEG_CLO;
            state_nxt = sts.r_zero ? fsd_pkg::ST_DONE : fsd_pkg::ST_SQ_MUL;
          end
          fsd_pkg::OP_FILLCIRCLE: begin
            seg_nxt   = fsd_pkg::SEG_FCIR;
            state_nxt = sts.r_zero ? fsd_pkg::ST_DONE : fsd_pkg::ST_SQ_MUL;
          end
          fsd_pkg::OP_READ: state_nxt = fsd_pkg::ST_RD_ADDR;
          default: state_nxt = fsd_pkg::ST_DONE;
        endcase
      end
      fsd_pkg::ST_SQ_MUL: state_nxt = fsd_pkg::ST_SQ_SUB;
      fsd_pkg::ST_SQ_SUB: state_nxt = fsd_pkg::ST_SQRT;
      fsd_pkg::ST_SQRT: begin
        if (!sts.sqrt_busy) state_nxt = fsd_pkg::ST_SET;
      end
      fsd_pkg::ST_DIV: begin
        if (!sts.div_busy) begin
          seg_nxt   = fsd_pkg::SEG_GV;
          state_nxt = fsd_pkg::ST_SET;
        end
      end
      fsd_pkg::ST_SET:  state_nxt = fsd_pkg::ST_ADDR;
      fsd_pkg::ST_ADDR: state_nxt = fsd_pkg::ST_RUN;
      fsd_pkg::ST_RUN: begin
        if (!sts.more) state_nxt = fsd_pkg::ST_NEXT;
      end
      fsd_pkg::ST_NEXT: begin
        state_nxt = fsd_pkg::ST_SET;
        case (seg_r)
          fsd_pkg::SEG_CLR, fsd_pkg::SEG_FRECT, fsd_pkg::SEG_GH: begin
            if (sts.last) state_nxt = fsd_pkg::ST_DONE;
          end
          fsd_pkg::SEG_TOP:  seg_nxt = fsd_pkg::SEG_BOT;
          fsd_pkg::SEG_BOT:  seg_nxt = fsd_pkg::SEG_LEFT;
          fsd_pkg::SEG_LEFT: seg_nxt = fsd_pkg::SEG_RIGHT;
          fsd_pkg::SEG_RIGHT: begin
            if (sts.op == fsd_pkg::OP_GRID && !sts.div_zero) state_nxt = fsd_pkg::ST_DIV;
            else state_nxt = fsd_pkg::ST_DONE;
          end
          fsd_pkg::SEG_GV: begin
            if (sts.last) seg_nxt = fsd_pkg::SEG_GH;
          end
          fsd_pkg::SEG_CLO: seg_nxt = fsd_pkg::SEG_CHI;
          fsd_pkg::SEG_CHI: begin
            seg_nxt   = fsd_pkg::SEG_CLO;
            state_nxt = sts.last ? fsd_pkg::ST_DONE : fsd_pkg::ST_SQ_MUL;
          end
          fsd_pkg::SEG_FCIR: begin
            state_nxt = sts.last ? fsd_pkg::ST_DONE : fsd_pkg::ST_SQ_MUL;
          end
          default: state_nxt = fsd_pkg::ST_DONE;
        endcase
      end
      fsd_pkg::ST_RD_ADDR: state_nxt = fsd_pkg::ST_RD_DATA;
      fsd_pkg::ST_RD_DATA: state_nxt = fsd_pkg::ST_DONE;
      fsd_pkg::ST_DONE: begin
        if (!sts.out_busy) state_nxt = fsd_pkg::ST_IDLE;
      end
      default: state_nxt = fsd_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd      = '0;
    cmd.seg  = seg_r;
    in_ready = 1'b0;
    case (state_r)
      fsd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fsd_pkg::ST_SQ_MUL: cmd.sq_mul = 1'b1;
      fsd_pkg::ST_SQ_SUB: cmd.sq_start = 1'b1;
      fsd_pkg::ST_DIV:    cmd.idx_clr = !sts.div_busy;
      fsd_pkg::ST_SET:    cmd.span_set = 1'b1;
      fsd_pkg::ST_ADDR:   cmd.span_addr = 1'b1;
      fsd_pkg::ST_RUN:    cmd.span_step = 1'b1;
      fsd_pkg::ST_NEXT: begin
        case (seg_r)
          fsd_pkg::SEG_CLR, fsd_pkg::SEG_FRECT, fsd_pkg::SEG_GH, fsd_pkg::SEG_CHI,
          fsd_pkg::SEG_FCIR: begin
            cmd.idx_inc = !sts.last;
          end
          fsd_pkg::SEG_GV: begin
            cmd.idx_clr = sts.last;
            cmd.idx_inc = !sts.last;
          end
          fsd_pkg::SEG_RIGHT: begin
            cmd.div_start = (sts.op == fsd_pkg::OP_GRID) && !sts.div_zero;
          end
          default: cmd.idx_inc = 1'b0;
        endcase
      end
      fsd_pkg::ST_RD_ADDR: cmd.rd_issue = 1'b1;
      fsd_pkg::ST_RD_DATA: cmd.rd_capture = 1'b1;
      fsd_pkg::ST_DONE:    cmd.out_load = !sts.out_busy;
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

// ----- rtl/fsd_dp.sv -----
// Datapath: command fields, span clipping and stepping, divider, square root, result word.
`timescale 1ns / 1ps
module fsd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [3:0]                          in_opcode,
  input  logic [fsd_pkg::POS_W-1:0]           in_pos_x,
  input  logic [fsd_pkg::POS_W-1:0]           in_pos_y,
  input  logic [fsd_pkg::POS_W-1:0]           in_end_x,
  input  logic [fsd_pkg::POS_W-1:0]           in_end_y,
  input  logic [fsd_pkg::POS_W-1:0]           in_size_w,
  input  logic [fsd_pkg::POS_W-1:0]           in_size_h,
  input  logic [fsd_pkg::DIV_W-1:0]           in_div_x,
  input  logic [fsd_pkg::DIV_W-1:0]           in_div_y,
  input  logic [fsd_pkg::POS_W-1:0]           in_diameter,
  input  logic [fsd_pkg::PIX_W-1:0]           in_paint,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [fsd_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [fsd_pkg::PIX_W-1:0]           out_pixel_value,
  output logic                                out_status,
  input  fsd_pkg::dp_cmd_t                    cmd,
  output fsd_pkg::dp_sts_t                    sts,
  output logic                                ram_we,
  output logic [fsd_pkg::ADDR_W-1:0]          ram_waddr,
  output logic [fsd_pkg::PIX_W-1:0]           ram_wdata,
  output logic                                ram_re,
  output logic [fsd_pkg::ADDR_W-1:0]          ram_raddr,
  input  logic [fsd_pkg::PIX_W-1:0]           ram_rdata
);

  localparam int AW = fsd_pkg::ADDR_W;
  localparam int DW = fsd_pkg::DIM_W;
  localparam logic [fsd_pkg::SQ_W-1:0] SQ_BIT0 = fsd_pkg::SQ_W'(1) << (fsd_pkg::SQ_W - 2);

  // Configuration
  logic [fsd_pkg::CFG_W-1:0] w_cfg_r, h_cfg_r;
  logic [DW-1:0]             w_eff, h_eff;
  fsd_pkg::crd_t             w_c, h_c;

  // Command fields
  logic [3:0]                  op_r;
  fsd_pkg::crd_t               px_r, py_r, ex_r, ey_r, sw_r, sh_r, r_r;
  logic [fsd_pkg::DIV_W-1:0]   dvx_r, dvy_r;
  logic [fsd_pkg::PIX_W-1:0]   paint_r;
  logic [fsd_pkg::SQ_W-1:0]    rsq_r;

  // Loop state
  logic [fsd_pkg::POS_W-1:0]   i_r;
  logic [fsd_pkg::POS_W:0]     i_p1;
  logic                        seg_last;
  fsd_pkg::crd_t               accx_r, accy_r, dx_r;
  logic [fsd_pkg::POS_W-1:0]   gx_r, gy_r;

  // Divider
  logic [fsd_pkg::DIV_W:0]     rem_r, rem_t;
  logic [fsd_pkg::POS_W-1:0]   quo_r, quo_t;
  logic [3:0]                  dcnt_r;
  logic                        dsel_r, dbusy_r;
  logic [fsd_pkg::DIV_W-1:0]   dvs;
  logic                        qbit;

  // Square root
  logic [fsd_pkg::SQ_W-1:0]    v_r, res_r, bit_r, dxsq_r, trial;
  logic [fsd_pkg::ROOT_W-1:0]  dxa;
  fsd_pkg::crd_t               s_c;

  // Span
  fsd_pkg::crd_t               sa, sb, sf, along, across, cur_r, end_r, fix_r;
  logic                        sh_horiz, horiz_r, span_ok, more;
  logic [AW-1:0]               addr_r, m_op, a_op;

  // Read and result
  logic                        rd_ok, rd_ok_r;
  logic [fsd_pkg::PIX_W-1:0]   pix_r;
  logic                        out_valid_r, out_status_r;
  logic [fsd_pkg::PIX_W-1:0]   out_pixel_r;

  // Clamp frame size registers
  always_comb begin
    if (w_cfg_r == '0) w_eff = DW'(1);
    else if (int'(w_cfg_r) > fsd_pkg::MAX_WIDTH) w_eff = DW'(fsd_pkg::MAX_WIDTH);
    else w_eff = DW'(w_cfg_r);
    if (h_cfg_r == '0) h_eff = DW'(1);
    else if (int'(h_cfg_r) > fsd_pkg::MAX_HEIGHT) h_eff = DW'(fsd_pkg::MAX_HEIGHT);
    else h_eff = DW'(h_cfg_r);
  end
  assign w_c = fsd_pkg::crd_t'(w_eff);
  assign h_c = fsd_pkg::crd_t'(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cfg_r <= fsd_pkg::CFG_RESET;
      h_cfg_r <= fsd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == fsd_pkg::CFG_FRAME_WIDTH) w_cfg_r <= cfg_data;
      if (cfg_index == fsd_pkg::CFG_FRAME_HEIGHT) h_cfg_r <= cfg_data;
    end
  end

  // Latch the command word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      px_r    <= fsd_pkg::crd_t'(in_pos_x);
      py_r    <= fsd_pkg::crd_t'(in_pos_y);
      ex_r    <= fsd_pkg::crd_t'(in_end_x);
      ey_r    <= fsd_pkg::crd_t'(in_end_y);
      sw_r    <= fsd_pkg::crd_t'(in_size_w);
      sh_r    <= fsd_pkg::crd_t'(in_size_h);
      dvx_r   <= in_div_x;
      dvy_r   <= in_div_y;
      paint_r <= in_paint;
      r_r     <= fsd_pkg::crd_t'(in_diameter[fsd_pkg::POS_W-1:1]);
      rsq_r   <= in_diameter[fsd_pkg::POS_W-1:1] * in_diameter[fsd_pkg::POS_W-1:1];
    end
  end

  // Loop counters and grid line positions
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_r    <= '0;
      accx_r <= fsd_pkg::crd_t'(in_pos_x);
      accy_r <= fsd_pkg::crd_t'(in_pos_y);
      dx_r   <= -fsd_pkg::crd_t'(in_diameter[fsd_pkg::POS_W-1:1]);
    end else if (cmd.idx_clr) begin
      i_r <= '0;
    end else if (cmd.idx_inc) begin
      i_r <= i_r + 1'b1;
      if (cmd.seg == fsd_pkg::SEG_GV) accx_r <= accx_r + fsd_pkg::crd_t'(gx_r);
      if (cmd.seg == fsd_pkg::SEG_GH) accy_r <= accy_r + fsd_pkg::crd_t'(gy_r);
      if (cmd.seg == fsd_pkg::SEG_CHI || cmd.seg == fsd_pkg::SEG_FCIR) dx_r <= dx_r + 1'b1;
    end
  end

  // Flag the final pass of the running loop
  assign i_p1 = {1'b0, i_r} + 1'b1;
  always_comb begin
    case (cmd.seg)
      fsd_pkg::SEG_CLR:   seg_last = (i_p1 == (fsd_pkg::POS_W + 1)'(h_eff));
      fsd_pkg::SEG_FRECT: seg_last = (i_p1 == (fsd_pkg::POS_W + 1)'(sh_r));
      fsd_pkg::SEG_GV:    seg_last = (i_p1 == (fsd_pkg::POS_W + 1)'(dvx_r));
      fsd_pkg::SEG_GH:    seg_last = (i_p1 == (fsd_pkg::POS_W + 1)'(dvy_r));
      fsd_pkg::SEG_CLO, fsd_pkg::SEG_CHI, fsd_pkg::SEG_FCIR:
        seg_last = (dx_r + 1'b1 == r_r);
      default: seg_last = 1'b1;
    endcase
  end

  // Restoring divider: grid step x, then grid step y
  assign dvs   = dsel_r ? dvy_r : dvx_r;
  assign rem_t = {rem_r[fsd_pkg::DIV_W-1:0], quo_r[fsd_pkg::POS_W-1]};
  assign qbit  = (rem_t >= {1'b0, dvs});
  assign quo_t = {quo_r[fsd_pkg::POS_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == 4'(fsd_pkg::POS_W - 1) && dsel_r) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsel_r <= 1'b0;
      dcnt_r <= '0;
      rem_r  <= '0;
      quo_r  <= sw_r[fsd_pkg::POS_W-1:0];
    end else if (dbusy_r) begin
      if (dcnt_r == 4'(fsd_pkg::POS_W - 1)) begin
        dcnt_r <= '0;
        rem_r  <= '0;
        if (!dsel_r) begin
          gx_r   <= quo_t;
          dsel_r <= 1'b1;
          quo_r  <= sh_r[fsd_pkg::POS_W-1:0];
        end else begin
          gy_r <= quo_t;
        end
      end else begin
        dcnt_r <= dcnt_r + 1'b1;
        rem_r  <= qbit ? rem_t - {1'b0, dvs} : rem_t;
        quo_r  <= quo_t;
      end
    end
  end

  // Square root of r*r - dx*dx, two bits of radicand a cycle
  assign dxa   = (dx_r < 0) ? fsd_pkg::ROOT_W'(-dx_r) : fsd_pkg::ROOT_W'(dx_r);
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else if (cmd.sq_start) begin
      bit_r <= SQ_BIT0;
    end else if (bit_r != '0) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) dxsq_r <= dxa * dxa;
    if (cmd.sq_start) begin
      v_r   <= rsq_r - dxsq_r;
      res_r <= '0;
    end else if (bit_r != '0) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end
  assign s_c = fsd_pkg::crd_t'(res_r[fsd_pkg::ROOT_W-1:0]);

  // Select span end points for the current segment
  always_comb begin
    sh_horiz = 1'b1;
    sa = px_r;
    sb = px_r + sw_r;
    sf = py_r;
    case (cmd.seg)
      fsd_pkg::SEG_CLR: begin
        sa = '0;
        sb = w_c;
        sf = fsd_pkg::crd_t'(i_r);
      end
      fsd_pkg::SEG_HS: begin
        sb = ex_r;
      end
      fsd_pkg::SEG_VS: begin
        sh_horiz = 1'b0;
        sa = py_r;
        sb = ey_r;
        sf = px_r;
      end
      fsd_pkg::SEG_FRECT: sf = py_r + fsd_pkg::crd_t'(i_r);
      fsd_pkg::SEG_TOP:   sf = py_r;
      fsd_pkg::SEG_BOT:   sf = py_r + sh_r;
      fsd_pkg::SEG_LEFT, fsd_pkg::SEG_RIGHT, fsd_pkg::SEG_GV: begin
        sh_horiz = 1'b0;
        sa = py_r;
        sb = py_r + sh_r;
        if (cmd.seg == fsd_pkg::SEG_LEFT) sf = px_r;
        else if (cmd.seg == fsd_pkg::SEG_RIGHT) sf = px_r + sw_r;
        else sf = accx_r;
      end
      fsd_pkg::SEG_GH: sf = accy_r;
      fsd_pkg::SEG_CLO, fsd_pkg::SEG_CHI: begin
        sa = px_r + dx_r;
        sb = px_r + dx_r + 1'b1;
        sf = (cmd.seg == fsd_pkg::SEG_CLO) ? py_r + s_c : py_r - s_c;
      end
      fsd_pkg::SEG_FCIR: begin
        sh_horiz = 1'b0;
        sa = py_r - s_c;
        sb = py_r + s_c;
        sf = px_r + dx_r;
      end
      default: sh_horiz = 1'b1;
    endcase
  end

  // Clip the span to the frame
  assign along   = sh_horiz ? w_c : h_c;
  assign across  = sh_horiz ? h_c : w_c;
  assign span_ok = (sf >= 0) && (sf < across);
  assign more    = (cur_r < end_r);

  assign m_op = horiz_r ? AW'(fix_r) : AW'(cur_r);
  assign a_op = horiz_r ? AW'(cur_r) : AW'(fix_r);

  always_ff @(posedge clk) begin
    if (cmd.span_set) begin
      horiz_r <= sh_horiz;
      fix_r   <= sf;
      cur_r   <= span_ok ? ((sa < 0) ? '0 : sa) : '0;
      end_r   <= span_ok ? ((sb > along) ? along : sb) : '0;
    end else if (cmd.span_addr) begin
      addr_r <= AW'(m_op * w_eff) + a_op;
    end else if (cmd.span_step && more) begin
      cur_r  <= cur_r + 1'b1;
      addr_r <= horiz_r ? addr_r + 1'b1 : addr_r + AW'(w_eff);
    end
  end

  // Pixel write port
  assign ram_we    = cmd.span_step && more;
  assign ram_waddr = addr_r;
  assign ram_wdata = paint_r;

  // Pixel read
  assign rd_ok     = (px_r < w_c) && (py_r < h_c);
  assign ram_re    = cmd.rd_issue;
  assign ram_raddr = AW'(AW'(py_r) * w_eff) + AW'(px_r);

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_ok_r <= rd_ok;
    if (cmd.load) pix_r <= '0;
    else if (cmd.rd_capture) pix_r <= rd_ok_r ? ram_rdata : '0;
  end

  // Result word: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_r  <= pix_r;
      out_status_r <= (op_r == fsd_pkg::OP_GRID) && (dvx_r == '0 || dvy_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_r;
  assign out_status      = out_status_r;

  // Status to the sequencer
  assign sts.op        = op_r;
  assign sts.more      = more;
  assign sts.last      = seg_last;
  assign sts.div_busy  = dbusy_r;
  assign sts.sqrt_busy = (bit_r != '0);
  assign sts.rows_zero = (sh_r == '0);
  assign sts.r_zero    = (r_r == '0);
  assign sts.div_zero  = (dvx_r == '0) || (dvy_r == '0);
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule
